// ===== design/sax_pkg.sv =====
// ----------------------------------------------------------------------------
// sax_pkg
// Shared constants and types for the symbolic aggregate approximation
// symbolizer: field widths, limits, configuration register indexes, action codes and states.
// ----------------------------------------------------------------------------
`default_nettype none

package sax_pkg;

  // field and state widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned SumW      = 24;
  localparam int unsigned ProdW     = 25;
  localparam int unsigned LenW      = 9;
  localparam int unsigned CntW      = 11;
  localparam int unsigned AlphaW    = 9;
  localparam int unsigned SymW      = 8;
  localparam int unsigned SlotW     = 8;
  localparam int unsigned SegIdxW   = 10;
  localparam int unsigned SamplePosW = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 11;

  // limits
  localparam int unsigned MaxSegLen   = 256;
  localparam int unsigned MaxSegments = 1024;
  localparam int unsigned MaxAlphabet = 256;
  localparam int unsigned TableDepth  = MaxAlphabet - 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SEGMENT_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEGMENT_COUNT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALPHABET_SIZE  = 2'd2;

  // input action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== design/sax_symbolizer_top.sv =====
// ----------------------------------------------------------------------------
// sax_symbolizer_top
// Accumulates Q8.8 samples into segments and, at each segment end, counts
// the loaded breakpoints lying strictly below the segment mean using one
// shared multiply and compare unit stepped over the breakpoint table.
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   cfg      | cfg_we_i               | cfg_index_i, cfg_wdata_i
//   in       | in_valid_i / in_ready_o| action_i, value_i, breakpoint_slot_i
//   out      | out_valid_o/out_ready_i| symbol_o, segment_index_o,
//            |                        | last_of_series_o
//
// a load or a sample inside a segment leaves the sequencer in ST_IDLE
// a sample that ends a segment starts a scan of alphabet_size - 1 table
// entries, one table entry per cycle into a read, multiply and compare
// pipeline, then the drain and emit states before the next transaction
// in_ready_o is low during the table scan and drain and while a result
// waits for a free output register; a result held in the output register only
// blocks the next segment end
// reset clears counters and sum, sets config defaults; the table is kept
`default_nettype none

module sax_symbolizer_top
  import sax_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic [CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [CfgDataW-1:0]        cfg_wdata_i,
  // input channel
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       action_i,
  input  wire logic signed [SampleW-1:0]  value_i,
  input  wire logic [SlotW-1:0]           breakpoint_slot_i,
  // output channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [SymW-1:0]                 symbol_o,
  output logic [SegIdxW-1:0]              segment_index_o,
  output logic                            last_of_series_o
);

  // configuration registers
  logic [LenW-1:0]   cfg_len_q;
  logic [CntW-1:0]   cfg_cnt_q;
  logic [AlphaW-1:0] cfg_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q   <= LenW'(1);
      cfg_cnt_q   <= CntW'(1);
      cfg_alpha_q <= AlphaW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SEGMENT_LENGTH: cfg_len_q   <= cfg_wdata_i[LenW-1:0];
        CFG_SEGMENT_COUNT:  cfg_cnt_q   <= cfg_wdata_i[CntW-1:0];
        CFG_ALPHABET_SIZE:  cfg_alpha_q <= cfg_wdata_i[AlphaW-1:0];
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [LenW-1:0]   len_c;
  logic [CntW-1:0]   cnt_c;
  logic [AlphaW-1:0] alpha_c;

  always_comb begin
    priority if (cfg_len_q == '0)                len_c = LenW'(1);
    else if (cfg_len_q > LenW'(MaxSegLen))       len_c = LenW'(MaxSegLen);
    else                                         len_c = cfg_len_q;
    priority if (cfg_cnt_q == '0)                cnt_c = CntW'(1);
    else if (cfg_cnt_q > CntW'(MaxSegments))     cnt_c = CntW'(MaxSegments);
    else                                         cnt_c = cfg_cnt_q;
    priority if (cfg_alpha_q < AlphaW'(2))       alpha_c = AlphaW'(2);
    else if (cfg_alpha_q > AlphaW'(MaxAlphabet)) alpha_c = AlphaW'(MaxAlphabet);
    else                                         alpha_c = cfg_alpha_q;
  end

  // state and datapath registers
  state_e                  state_q, state_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [SamplePosW-1:0]   spos_q, spos_d;
  logic [SegIdxW-1:0]      segpos_q, segpos_d;
  logic [SegIdxW-1:0]      pend_idx_q, pend_idx_d;
  logic                    pend_last_q, pend_last_d;
  logic [SlotW-1:0]        addr_q, addr_d;
  logic [SymW-1:0]         sym_q, sym_d;
  logic                    rd_vld_q, mul_vld_q;
  logic signed [SampleW-1:0] rd_data_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    out_valid_q;
  logic [SymW-1:0]         out_sym_q;
  logic [SegIdxW-1:0]      out_idx_q;
  logic                    out_last_q;
  logic                    out_load;

  logic in_fire, sample_fire, load_fire, seg_end, series_end, last_issue;
  logic [SamplePosW:0] spos_inc;
  logic [CntW-1:0]     segpos_inc;

  assign in_fire     = in_valid_i && in_ready_o;
  assign sample_fire = in_fire && (action_i == ACT_SAMPLE);
  assign load_fire   = in_fire && (action_i == ACT_LOAD);
  assign spos_inc    = {1'b0, spos_q} + (SamplePosW+1)'(1);
  assign segpos_inc  = CntW'(segpos_q) + CntW'(1);
  assign seg_end     = spos_inc >= len_c;
  assign series_end  = segpos_inc >= cnt_c;
  assign last_issue  = {1'b0, addr_q} == (alpha_c - AlphaW'(2));

  // breakpoint table
  logic signed [SampleW-1:0] bp_mem [TableDepth];

  always_ff @(posedge clk_i) begin
    if (load_fire && (breakpoint_slot_i < SlotW'(TableDepth))) begin
      bp_mem[breakpoint_slot_i] <= value_i;
    end
    rd_data_q <= bp_mem[addr_q];
  end

  // shared multiply unit: breakpoint times segment length
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(rd_data_q * $signed({1'b0, len_c}));
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    spos_d      = spos_q;
    segpos_d    = segpos_q;
    pend_idx_d  = pend_idx_q;
    pend_last_d = pend_last_q;
    addr_d      = addr_q;
    sym_d       = sym_q;
    out_load    = 1'b0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (sample_fire) begin
          sum_d = sum_q + SumW'(value_i);
          if (seg_end) begin
            spos_d      = '0;
            pend_idx_d  = segpos_q;
            pend_last_d = series_end;
            segpos_d    = series_end ? '0 : segpos_inc[SegIdxW-1:0];
            addr_d      = '0;
            sym_d       = '0;
            state_d     = ST_SCAN;
          end else begin
            spos_d = spos_inc[SamplePosW-1:0];
          end
        end
      end
      ST_SCAN: begin
        // one table read issued per cycle
        if (last_issue) begin
          state_d = ST_DRAIN;
        end else begin
          addr_d = addr_q + SlotW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !mul_vld_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          sum_d    = '0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // compare stage: count breakpoints below the mean
    if (mul_vld_q && (prod_q < ProdW'(sum_q))) begin
      sym_d = sym_q + SymW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      spos_q      <= '0;
      segpos_q    <= '0;
      pend_idx_q  <= '0;
      pend_last_q <= 1'b0;
      addr_q      <= '0;
      sym_q       <= '0;
      rd_vld_q    <= 1'b0;
      mul_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      spos_q      <= spos_d;
      segpos_q    <= segpos_d;
      pend_idx_q  <= pend_idx_d;
      pend_last_q <= pend_last_d;
      addr_q      <= addr_d;
      sym_q       <= sym_d;
      rd_vld_q    <= (state_q == ST_SCAN);
      mul_vld_q   <= rd_vld_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sym_q  <= sym_q;
      out_idx_q  <= pend_idx_q;
      out_last_q <= pend_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign symbol_o         = out_sym_q;
  assign segment_index_o  = out_idx_q;
  assign last_of_series_o = out_last_q;

`ifndef SYNTH
  // a segment-ending sample starts the table scan
  a_seg_end_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_fire && seg_end) |=> (state_q == ST_SCAN))
    else $error("segment end did not start the scan");

  // the count never exceeds the number of active breakpoints
  a_sym_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> ({1'b0, sym_q} <= (alpha_c - AlphaW'(1))))
    else $error("symbol count exceeds active breakpoints");

  // the segment counter has wrapped when the final segment is emitted
  a_last_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && pend_last_q) |-> (segpos_q == '0))
    else $error("segment position not wrapped at series end");

  // the read and multiply stages only run during the scan and drain states
  a_pipe_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q || mul_vld_q) |-> ((state_q == ST_SCAN) || (state_q == ST_DRAIN)))
    else $error("scan pipeline active outside the scan");
`endif

endmodule

`default_nettype wire
